FILE: rtl/resp_array_stream_parser_top_defines.svh
// Assertion helpers used by the parser RTL.
`ifndef RESP_ARRAY_STREAM_PARSER_TOP_DEFINES_SVH
`define RESP_ARRAY_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RASP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RASP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rasp_pkg.sv
package rasp_pkg;

  localparam int IDX_W = 31;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_COUNT,
    PH_COUNT_LF,
    PH_PREFIX,
    PH_LEN,
    PH_LEN_LF,
    PH_PAYLOAD,
    PH_SKIP
  } phase_t;

  localparam logic [1:0] KIND_PAYLOAD     = 2'd0;
  localparam logic [1:0] KIND_EMPTY_ELEM  = 2'd1;
  localparam logic [1:0] KIND_EMPTY_ARRAY = 2'd2;
  localparam logic [1:0] KIND_ERROR       = 2'd3;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_STAR    = 3'd1;
  localparam logic [2:0] ERR_BAD_COUNT  = 3'd2;
  localparam logic [2:0] ERR_NO_DOLLAR  = 3'd3;
  localparam logic [2:0] ERR_BAD_LENGTH = 3'd4;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       payload;
    logic [IDX_W-1:0] element_index;
    logic             element_end;
    logic             array_end;
    logic [2:0]       error_code;
  } result_t;

endpackage

FILE: rtl/resp_array_stream_parser_top.sv
// Byte-serial parser for request arrays of bulk strings. One byte is taken per
// clock cycle whenever the output register is empty or is being drained in the
// same cycle; each byte is decoded in a single pass through the header state
// machine and its result, if any, is registered in the output register.
// Sustained rate is one byte per cycle, set only by downstream tready.
// Results: kind 0 per payload byte, kind 1 for an empty element, kind 2 for an
// empty or negative-count array, kind 3 for a framing error (then back to
// idle). tlast marks the result that ends an array. COUNT_BITS bounds counts
// and lengths to 2^COUNT_BITS-1.
`include "resp_array_stream_parser_top_defines.svh"

module resp_array_stream_parser_top #(
  parameter int COUNT_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload, [38:8] element_index, [41:39] error_code, [47:42] zero
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] element_end
  output logic        m_axis_tlast    // array_end
);
  import rasp_pkg::*;

  localparam int WIDE_W = COUNT_BITS + 4;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] number_accum, number_accum_next;
  logic                  number_negative, number_negative_next;
  logic                  number_has_digit, number_has_digit_next;
  logic [COUNT_BITS-1:0] elements_left, elements_left_next;
  logic [COUNT_BITS-1:0] current_element, current_element_next;
  logic [COUNT_BITS-1:0] bytes_left, bytes_left_next;
  logic [1:0]            skip_left, skip_left_next;

  logic                  in_fire;
  logic [7:0]            b;
  logic                  is_digit;
  logic [WIDE_W-1:0]     accum_wide;
  logic                  accum_ovf;
  logic                  clear_all;

  logic                  res_valid;
  result_t               res;
  result_t               out_reg;
  logic                  out_valid;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_digit      = (b >= CH_ZERO) && (b <= CH_NINE);

  // Times ten as two shifted copies, plus the digit.
  assign accum_wide = (WIDE_W'(number_accum) << 3) + (WIDE_W'(number_accum) << 1)
                    + WIDE_W'(b[3:0]);
  assign accum_ovf  = |accum_wide[WIDE_W-1:COUNT_BITS];

  // Next-state logic.
  always_comb begin
    phase_next            = phase;
    number_accum_next     = number_accum;
    number_negative_next  = number_negative;
    number_has_digit_next = number_has_digit;
    elements_left_next    = elements_left;
    current_element_next  = current_element;
    bytes_left_next       = bytes_left;
    skip_left_next        = skip_left;
    clear_all             = 1'b0;
    if (in_fire) begin
      case (phase)
        PH_IDLE: begin
          if (b != CH_STAR) begin
            clear_all = 1'b1;
          end else begin
            number_accum_next     = '0;
            number_negative_next  = 1'b0;
            number_has_digit_next = 1'b0;
            current_element_next  = '0;
            phase_next            = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (is_digit) begin
            if (accum_ovf) begin
              clear_all = 1'b1;
            end else begin
              number_accum_next     = accum_wide[COUNT_BITS-1:0];
              number_has_digit_next = 1'b1;
            end
          end else if (b == CH_MINUS && !number_has_digit && !number_negative) begin
            number_negative_next = 1'b1;
          end else if (b == CH_CR) begin
            phase_next = PH_COUNT_LF;
          end else begin
            clear_all = 1'b1;
          end
        end
        PH_COUNT_LF: begin
          if (b != CH_LF || !number_has_digit || number_negative ||
              number_accum == '0) begin
            clear_all = 1'b1;
          end else begin
            elements_left_next    = number_accum;
            current_element_next  = '0;
            number_accum_next     = '0;
            number_negative_next  = 1'b0;
            number_has_digit_next = 1'b0;
            phase_next            = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (b != CH_DOLLAR) begin
            clear_all = 1'b1;
          end else begin
            number_accum_next     = '0;
            number_negative_next  = 1'b0;
            number_has_digit_next = 1'b0;
            phase_next            = PH_LEN;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            if (accum_ovf) begin
              clear_all = 1'b1;
            end else begin
              number_accum_next     = accum_wide[COUNT_BITS-1:0];
              number_has_digit_next = 1'b1;
            end
          end else if (b == CH_CR) begin
            phase_next = PH_LEN_LF;
          end else begin
            clear_all = 1'b1;
          end
        end
        PH_LEN_LF: begin
          if (b != CH_LF || !number_has_digit) begin
            clear_all = 1'b1;
          end else begin
            number_accum_next     = '0;
            number_negative_next  = 1'b0;
            number_has_digit_next = 1'b0;
            if (number_accum == '0) begin
              skip_left_next = 2'd2;
              phase_next     = PH_SKIP;
            end else begin
              bytes_left_next = number_accum;
              phase_next      = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (bytes_left <= COUNT_BITS'(1)) begin
            bytes_left_next = '0;
            skip_left_next  = 2'd2;
            phase_next      = PH_SKIP;
          end else begin
            bytes_left_next = bytes_left - COUNT_BITS'(1);
          end
        end
        PH_SKIP: begin
          if (skip_left <= 2'd1) begin
            skip_left_next = 2'd0;
            if (elements_left <= COUNT_BITS'(1)) begin
              clear_all = 1'b1;
            end else begin
              elements_left_next   = elements_left - COUNT_BITS'(1);
              current_element_next = current_element + COUNT_BITS'(1);
              phase_next           = PH_PREFIX;
            end
          end else begin
            skip_left_next = skip_left - 2'd1;
          end
        end
        default: begin
          clear_all = 1'b1;
        end
      endcase
      if (clear_all) begin
        phase_next            = PH_IDLE;
        number_accum_next     = '0;
        number_negative_next  = 1'b0;
        number_has_digit_next = 1'b0;
        elements_left_next    = '0;
        current_element_next  = '0;
        bytes_left_next       = '0;
        skip_left_next        = 2'd0;
      end
    end
  end

  // Result logic.
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (in_fire) begin
      case (phase)
        PH_IDLE: begin
          if (b != CH_STAR) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NO_STAR;
          end
        end
        PH_COUNT: begin
          if ((is_digit && accum_ovf) ||
              (!is_digit && b != CH_CR &&
               !(b == CH_MINUS && !number_has_digit && !number_negative))) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_BAD_COUNT;
          end
        end
        PH_COUNT_LF: begin
          if (b != CH_LF || !number_has_digit) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_BAD_COUNT;
          end else if (number_negative || number_accum == '0) begin
            res_valid     = 1'b1;
            res.kind      = KIND_EMPTY_ARRAY;
            res.array_end = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (b != CH_DOLLAR) begin
            res_valid         = 1'b1;
            res.kind          = KIND_ERROR;
            res.element_index = IDX_W'(current_element);
            res.error_code    = ERR_NO_DOLLAR;
          end
        end
        PH_LEN: begin
          if ((is_digit && accum_ovf) || (!is_digit && b != CH_CR)) begin
            res_valid         = 1'b1;
            res.kind          = KIND_ERROR;
            res.element_index = IDX_W'(current_element);
            res.error_code    = ERR_BAD_LENGTH;
          end
        end
        PH_LEN_LF: begin
          if (b != CH_LF || !number_has_digit) begin
            res_valid         = 1'b1;
            res.kind          = KIND_ERROR;
            res.element_index = IDX_W'(current_element);
            res.error_code    = ERR_BAD_LENGTH;
          end else if (number_accum == '0) begin
            res_valid         = 1'b1;
            res.kind          = KIND_EMPTY_ELEM;
            res.element_index = IDX_W'(current_element);
            res.element_end   = 1'b1;
            res.array_end     = (elements_left == COUNT_BITS'(1));
          end
        end
        PH_PAYLOAD: begin
          res_valid         = 1'b1;
          res.kind          = KIND_PAYLOAD;
          res.payload       = b;
          res.element_index = IDX_W'(current_element);
          res.element_end   = (bytes_left <= COUNT_BITS'(1));
          res.array_end     = (bytes_left <= COUNT_BITS'(1)) &&
                              (elements_left == COUNT_BITS'(1));
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      number_accum     <= '0;
      number_negative  <= 1'b0;
      number_has_digit <= 1'b0;
      elements_left    <= '0;
      current_element  <= '0;
      bytes_left       <= '0;
      skip_left        <= 2'd0;
      out_valid        <= 1'b0;
    end else begin
      phase            <= phase_next;
      number_accum     <= number_accum_next;
      number_negative  <= number_negative_next;
      number_has_digit <= number_has_digit_next;
      elements_left    <= elements_left_next;
      current_element  <= current_element_next;
      bytes_left       <= bytes_left_next;
      skip_left        <= skip_left_next;
      if (s_axis_tready) begin
        out_valid <= res_valid;
      end
    end
  end

  // Output register loads a new result whenever the slot is free or draining.
  always_ff @(posedge clk) begin
    if (s_axis_tready && res_valid) begin
      out_reg <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_reg.error_code, out_reg.element_index, out_reg.payload};
  assign m_axis_tuser  = {out_reg.element_end, out_reg.kind};
  assign m_axis_tlast  = out_reg.array_end;

  `RASP_ASSERT_NOW(a_payload_has_bytes, phase == PH_PAYLOAD, bytes_left != '0,
    "payload phase with no bytes left")
  `RASP_ASSERT_NOW(a_skip_has_count, phase == PH_SKIP, skip_left != 2'd0,
    "skip phase with no bytes to skip")
  `RASP_ASSERT_NOW(a_error_coded,
    out_valid && out_reg.kind == KIND_ERROR,
    out_reg.error_code != ERR_NONE && !out_reg.array_end && !out_reg.element_end,
    "error result with inconsistent flags")
  `RASP_ASSERT_NOW(a_nonerror_clean,
    out_valid && out_reg.kind != KIND_ERROR, out_reg.error_code == ERR_NONE,
    "non-error result carries an error code")
  `RASP_ASSERT_NEXT(a_star_starts_count,
    in_fire && phase == PH_IDLE && b == CH_STAR, phase == PH_COUNT,
    "array prefix did not start the count line")

endmodule

FILE: tb/resp_array_stream_parser_top_tb.sv
`timescale 1ns / 100ps

module resp_array_stream_parser_top_tb;
  import rasp_pkg::*;

  localparam int               IDLE_LIMIT   = 2000;
  localparam int               RANDOM_BYTES = 1100;
  localparam longint unsigned  COUNT_MAX    = (64'd1 << IDX_W) - 1;

  typedef struct {
    logic [7:0] data;
    bit         pinned;
    result_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  resp_array_stream_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // Parser state mirrored by the testbench.
  phase_t           ph;
  logic [31:0]      num_acc;
  bit               num_neg;
  bit               num_has_digit;
  logic [IDX_W-1:0] elems_left;
  logic [IDX_W-1:0] cur_elem;
  logic [IDX_W-1:0] payload_left;
  logic [1:0]       trailer_left;

  result_t    pending_results[$];
  stim_row_t  directed_table[$];
  logic [7:0] msg_bytes[$];

  logic    cur_pinned;
  result_t cur_want;
  bit      calm;

  int fail_count;
  int idle_cycles;
  int bytes_sent;
  int random_bytes;
  int messages;
  int broken_messages;
  int kind_seen[4];

  function automatic result_t make_result(logic [1:0] k, logic [7:0] p,
                                          logic [IDX_W-1:0] idx, logic ee,
                                          logic ae, logic [2:0] ec);
    result_t r;
    r.kind          = k;
    r.payload       = p;
    r.element_index = idx;
    r.element_end   = ee;
    r.array_end     = ae;
    r.error_code    = ec;
    return r;
  endfunction

  function automatic stim_row_t plain(logic [7:0] b);
    stim_row_t s;
    s.data   = b;
    s.pinned = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  function automatic stim_row_t pinned(logic [7:0] b, result_t r);
    stim_row_t s;
    s.data   = b;
    s.pinned = 1'b1;
    s.want   = r;
    return s;
  endfunction

  task automatic queue_row(input stim_row_t row);
    directed_table.insert(directed_table.size(), row);
  endtask

  task automatic expect_result(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic put_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endtask

  task automatic clear_number();
    num_acc       = '0;
    num_neg       = 1'b0;
    num_has_digit = 1'b0;
  endtask

  task automatic parser_go_idle();
    ph = PH_IDLE;
    clear_number();
    elems_left   = '0;
    cur_elem     = '0;
    payload_left = '0;
    trailer_left = '0;
  endtask

  task automatic parser_error(input logic [2:0] code, output bit emits,
                              output result_t r);
    logic [IDX_W-1:0] idx;
    idx = (code == ERR_NO_DOLLAR || code == ERR_BAD_LENGTH) ? cur_elem : '0;
    parser_go_idle();
    emits = 1'b1;
    r = make_result(KIND_ERROR, 8'h00, idx, 1'b0, 1'b0, code);
  endtask

  task automatic take_digit(input logic [7:0] b, output bit ok);
    longint unsigned v;
    v = 64'(num_acc);
    v = v * 10 + (b - CH_ZERO);
    ok = (v <= COUNT_MAX);
    if (ok) begin
      num_acc       = v[31:0];
      num_has_digit = 1'b1;
    end
  endtask

  // Advances the mirrored parser by one byte and returns the result it causes.
  task automatic parse_byte(input logic [7:0] b, output bit emits, output result_t r);
    bit is_digit;
    bit ok;
    bit ee;
    is_digit = (b >= CH_ZERO && b <= CH_NINE);
    emits = 1'b0;
    r = '0;
    case (ph)
      PH_IDLE: begin
        if (b != CH_STAR) begin
          parser_error(ERR_NO_STAR, emits, r);
        end else begin
          clear_number();
          cur_elem = '0;
          ph = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (is_digit) begin
          take_digit(b, ok);
          if (!ok) parser_error(ERR_BAD_COUNT, emits, r);
        end else if (b == CH_MINUS && !num_has_digit && !num_neg) begin
          num_neg = 1'b1;
        end else if (b == CH_CR) begin
          ph = PH_COUNT_LF;
        end else begin
          parser_error(ERR_BAD_COUNT, emits, r);
        end
      end
      PH_COUNT_LF: begin
        if (b != CH_LF || !num_has_digit) begin
          parser_error(ERR_BAD_COUNT, emits, r);
        end else if (num_neg || num_acc == 0) begin
          parser_go_idle();
          emits = 1'b1;
          r = make_result(KIND_EMPTY_ARRAY, 8'h00, '0, 1'b0, 1'b1, ERR_NONE);
        end else begin
          elems_left = num_acc[IDX_W-1:0];
          cur_elem = '0;
          clear_number();
          ph = PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        if (b != CH_DOLLAR) begin
          parser_error(ERR_NO_DOLLAR, emits, r);
        end else begin
          clear_number();
          ph = PH_LEN;
        end
      end
      PH_LEN: begin
        if (is_digit) begin
          take_digit(b, ok);
          if (!ok) parser_error(ERR_BAD_LENGTH, emits, r);
        end else if (b == CH_CR) begin
          ph = PH_LEN_LF;
        end else begin
          parser_error(ERR_BAD_LENGTH, emits, r);
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF || !num_has_digit) begin
          parser_error(ERR_BAD_LENGTH, emits, r);
        end else if (num_acc == 0) begin
          clear_number();
          trailer_left = 2'd2;
          ph = PH_SKIP;
          emits = 1'b1;
          r = make_result(KIND_EMPTY_ELEM, 8'h00, cur_elem, 1'b1, elems_left == 1,
                          ERR_NONE);
        end else begin
          payload_left = num_acc[IDX_W-1:0];
          clear_number();
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ee = (payload_left <= 1);
        emits = 1'b1;
        r = make_result(KIND_PAYLOAD, b, cur_elem, ee, ee && elems_left == 1,
                        ERR_NONE);
        if (payload_left > 0) payload_left = IDX_W'(payload_left - 1);
        if (ee) begin
          payload_left = '0;
          trailer_left = 2'd2;
          ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (trailer_left > 0) trailer_left = 2'(trailer_left - 1);
        if (trailer_left == 0) begin
          if (elems_left <= 1) begin
            parser_go_idle();
          end else begin
            elems_left = IDX_W'(elems_left - 1);
            cur_elem = IDX_W'(cur_elem + 1);
            ph = PH_PREFIX;
          end
        end
      end
      default: parser_go_idle();
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  // Acceptance on both sides, result checking and the watchdog.
  always @(posedge clk) begin
    bit      emits;
    result_t r;
    result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d code %0d",
                                    m_axis_tuser[1:0], m_axis_tdata[41:39]));
        end else begin
          want = pending_results.pop_front();
          kind_seen[want.kind]++;
          if (m_axis_tuser[1:0] !== want.kind)
            report_mismatch($sformatf("kind got %0d expected %0d",
                                      m_axis_tuser[1:0], want.kind));
          if (m_axis_tdata[7:0] !== want.payload)
            report_mismatch($sformatf("payload got 0x%02h expected 0x%02h",
                                      m_axis_tdata[7:0], want.payload));
          if (m_axis_tdata[38:8] !== want.element_index)
            report_mismatch($sformatf("element_index got %0d expected %0d",
                                      m_axis_tdata[38:8], want.element_index));
          if (m_axis_tuser[2] !== want.element_end)
            report_mismatch($sformatf("element_end got %b expected %b",
                                      m_axis_tuser[2], want.element_end));
          if (m_axis_tlast !== want.array_end)
            report_mismatch($sformatf("array_end got %b expected %b",
                                      m_axis_tlast, want.array_end));
          if (m_axis_tdata[41:39] !== want.error_code)
            report_mismatch($sformatf("error_code got %0d expected %0d",
                                      m_axis_tdata[41:39], want.error_code));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, emits, r);
        // Pinned rows carry a hand-written expectation instead of the predicted one.
        if (cur_pinned) expect_result(cur_want);
        else if (emits) expect_result(r);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Downstream: bursts of readiness, mostly short stalls, a few long ones.
  initial begin
    int burst;
    int stall;
    int pick;
    m_axis_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 70) burst = $urandom_range(1, 8);
      else if (pick < 95) burst = $urandom_range(9, 40);
      else burst = $urandom_range(100, 300);
      m_axis_tready <= 1'b1;
      repeat (burst) @(negedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 40) stall = 0;
      else if (pick < 90) stall = $urandom_range(1, 3);
      else stall = $urandom_range(10, 40);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input bit pin, input result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    cur_pinned    <= pin;
    cur_want      <= want;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] pick_byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
    return v;
  endfunction

  // Any byte that is neither a digit, a CR nor a minus sign.
  function automatic logic [7:0] pick_non_numeric();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while ((v >= CH_ZERO && v <= CH_NINE) || v == CH_CR || v == CH_MINUS);
    return v;
  endfunction

  task automatic put_decimal(input longint unsigned v);
    logic [7:0] digits[$];
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
    if (v == 0) digits.push_front(CH_ZERO);
    while (v > 0) begin
      digits.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end
    foreach (digits[i]) put_byte(digits[i]);
  endtask

  task automatic put_crlf();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic put_element();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 15) len = 0;
    else if (pick < 85) len = $urandom_range(1, 8);
    else if (pick < 97) len = $urandom_range(9, 40);
    else len = $urandom_range(41, 200);
    put_byte(CH_DOLLAR);
    put_decimal(64'(len));
    put_crlf();
    repeat (len) put_byte(8'($urandom_range(0, 255)));
    // The trailer is not checked by the parser, so it is often garbage.
    if ($urandom_range(0, 1)) begin
      put_crlf();
    end else begin
      put_byte(8'($urandom_range(0, 255)));
      put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_array_head(input int total, input int complete);
    put_byte(CH_STAR);
    put_decimal(64'(total));
    put_crlf();
    repeat (complete) put_element();
  endtask

  // Builds one message; broken ones end at the byte that raises the error.
  task automatic build_message();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    msg_bytes.delete();
    if (pick < 60) begin
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      put_array_head(n, n);
    end else if (pick < 68) begin
      put_byte(CH_STAR);
      case ($urandom_range(0, 2))
        0: put_decimal(0);
        1: begin
          put_byte(CH_MINUS);
          put_decimal(64'($urandom_range(0, 999)));
        end
        default: begin
          put_byte(CH_MINUS);
          put_decimal(COUNT_MAX);
        end
      endcase
      put_crlf();
    end else if (pick < 72) begin
      broken_messages++;
      put_byte(pick_byte_except(CH_STAR, CH_STAR));
    end else if (pick < 82) begin
      broken_messages++;
      put_byte(CH_STAR);
      case ($urandom_range(0, 7))
        0: put_byte(pick_non_numeric());
        1: begin
          put_decimal(64'($urandom_range(0, 999)));
          put_byte(CH_MINUS);
        end
        2: begin
          put_byte(CH_MINUS);
          put_byte(CH_MINUS);
        end
        3: put_crlf();
        4: begin
          put_byte(CH_MINUS);
          put_crlf();
        end
        5: begin
          put_decimal(64'($urandom_range(1, 99)));
          put_byte(CH_CR);
          put_byte(pick_byte_except(CH_LF, CH_LF));
        end
        6: put_decimal(COUNT_MAX + 1);
        default: put_decimal(64'd9999999999);
      endcase
    end else if (pick < 90) begin
      broken_messages++;
      n = $urandom_range(1, 3);
      put_array_head(n, $urandom_range(0, n - 1));
      put_byte(pick_byte_except(CH_DOLLAR, CH_DOLLAR));
    end else begin
      broken_messages++;
      if ($urandom_range(0, 9) == 0) begin
        put_array_head(int'(COUNT_MAX), 0);
      end else begin
        n = $urandom_range(1, 3);
        put_array_head(n, $urandom_range(0, n - 1));
      end
      put_byte(CH_DOLLAR);
      case ($urandom_range(0, 5))
        0: put_byte(CH_MINUS);
        1: begin
          put_decimal(64'($urandom_range(0, 99)));
          put_byte(pick_non_numeric());
        end
        2: put_crlf();
        3: begin
          put_decimal(64'($urandom_range(0, 99)));
          put_byte(CH_CR);
          put_byte(pick_byte_except(CH_LF, CH_LF));
        end
        4: put_decimal(COUNT_MAX + 1);
        default: put_decimal(64'd9999999999);
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cur_pinned = 1'b0;
    cur_want = '0;
    calm = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    bytes_sent = 0;
    random_bytes = 0;
    messages = 0;
    broken_messages = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    parser_go_idle();

    // Stray bytes at idle, a negative count, a three-element array with one
    // payload byte and one empty element, then a missing '$' and a bad count.
    queue_row(pinned(8'h00,
      make_result(KIND_ERROR, 8'h00, '0, 1'b0, 1'b0, ERR_NO_STAR)));
    queue_row(pinned(8'hFF,
      make_result(KIND_ERROR, 8'h00, '0, 1'b0, 1'b0, ERR_NO_STAR)));
    queue_row(plain(CH_STAR));
    queue_row(plain(CH_MINUS));
    queue_row(plain(CH_ZERO + 8'd7));
    queue_row(plain(CH_CR));
    queue_row(pinned(CH_LF,
      make_result(KIND_EMPTY_ARRAY, 8'h00, '0, 1'b0, 1'b1, ERR_NONE)));
    queue_row(plain(CH_STAR));
    queue_row(plain(CH_ZERO + 8'd3));
    queue_row(plain(CH_CR));
    queue_row(plain(CH_LF));
    queue_row(plain(CH_DOLLAR));
    queue_row(plain(CH_ZERO + 8'd1));
    queue_row(plain(CH_CR));
    queue_row(plain(CH_LF));
    queue_row(pinned(8'h80,
      make_result(KIND_PAYLOAD, 8'h80, '0, 1'b1, 1'b0, ERR_NONE)));
    queue_row(plain(8'h00));
    queue_row(plain(8'hFF));
    queue_row(plain(CH_DOLLAR));
    queue_row(plain(CH_ZERO));
    queue_row(plain(CH_CR));
    queue_row(pinned(CH_LF,
      make_result(KIND_EMPTY_ELEM, 8'h00, 31'd1, 1'b1, 1'b0, ERR_NONE)));
    queue_row(plain(CH_CR));
    queue_row(plain(CH_LF));
    queue_row(pinned(8'h23,
      make_result(KIND_ERROR, 8'h00, 31'd2, 1'b0, 1'b0, ERR_NO_DOLLAR)));
    queue_row(plain(CH_STAR));
    queue_row(pinned(8'h78,
      make_result(KIND_ERROR, 8'h00, '0, 1'b0, 1'b0, ERR_BAD_COUNT)));

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_table[i])
      send_byte(directed_table[i].data, directed_table[i].pinned, directed_table[i].want);
    wait_for_results();

    while (random_bytes < RANDOM_BYTES) begin
      build_message();
      calm = ($urandom_range(0, 3) == 0);
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], 1'b0, '0);
      random_bytes += msg_bytes.size();
      messages++;
      if (messages % 40 == 0) wait_for_results();
    end

    wait_for_results();
    repeat (20) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Sent %0d bytes (%0d random messages, %0d of them malformed).",
             bytes_sent, messages, broken_messages);
    $display("Checked %0d payload, %0d empty element, %0d empty array, %0d error results.",
             kind_seen[KIND_PAYLOAD], kind_seen[KIND_EMPTY_ELEM],
             kind_seen[KIND_EMPTY_ARRAY], kind_seen[KIND_ERROR]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: resp_array_stream_parser_top.f
+incdir+rtl
rtl/rasp_pkg.sv
rtl/resp_array_stream_parser_top.sv
tb/resp_array_stream_parser_top_tb.sv
